FILE: design/pipg_pkg.sv
// Shared types and constants for the point-in-polygon gate.
// No dependencies; every other file refers into this package by scoped name.
`timescale 1ns / 1ps

package pipg_pkg;

   localparam int COORD_W    = 32;
   localparam int INDEX_W    = 32;
   localparam int SLOT_W     = 4;
   localparam int VCOUNT_W   = 5;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int MAG_W      = COORD_W;
   localparam int PROD_W     = 2 * MAG_W;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam int MIN_VERTICES = 3;
   localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = VCOUNT_W'(3);

   // opcode field
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_POINT = 1'b1;

   // register index, taken from paddr[2]
   localparam logic CSR_IDX_VCOUNT = 1'b0;
   localparam logic CSR_IDX_NEGATE = 1'b1;

   typedef logic signed [COORD_W-1:0] pipg_coord_type;

   // edge endpoints handed to one lane at stage 1
   typedef struct packed {
      pipg_coord_type x1;
      pipg_coord_type y1;
      pipg_coord_type x2;
      pipg_coord_type y2;
      logic           active;
   } pipg_lane_in_type;

   // load enables of the lane stages
   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } pipg_stage_en_type;

   // per-edge verdict at stage 5
   typedef struct packed {
      logic crosses;
      logic on_edge;
      logic top_hit;
   } pipg_lane_out_type;

endpackage

FILE: design/pipg_req_if.sv
// Input channel: valid/ready handshake carrying a vertex load or a point.
// Depends on pipg_pkg.
`timescale 1ns / 1ps

interface pipg_req_if;
   logic                                valid;
   logic                                ready;
   logic                                opcode;
   logic [pipg_pkg::SLOT_W-1:0]         vertex_slot;
   pipg_pkg::pipg_coord_type            coord_x;
   pipg_pkg::pipg_coord_type            coord_y;
   logic [pipg_pkg::INDEX_W-1:0]        event_index;

   modport source (output valid, opcode, vertex_slot, coord_x, coord_y, event_index,
                   input ready);
   modport sink   (input valid, opcode, vertex_slot, coord_x, coord_y, event_index,
                   output ready);
endinterface

FILE: design/pipg_rsp_if.sv
// Result channel: valid/ready handshake carrying a selected point index.
// Depends on pipg_pkg.
`timescale 1ns / 1ps

interface pipg_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pipg_pkg::INDEX_W-1:0] selected_index;

   modport source (output valid, selected_index, input ready);
   modport sink   (input valid, selected_index, output ready);
endinterface

FILE: design/pipg_edge_lane.sv
// One polygon edge tested against the point, stages 2 to 5 of the pipeline.
// Depends on pipg_pkg.
`timescale 1ns / 1ps

module pipg_edge_lane (
   input  logic                        clock,
   input  pipg_pkg::pipg_stage_en_type en,
   input  pipg_pkg::pipg_lane_in_type  edge_in,
   input  pipg_pkg::pipg_coord_type    px,
   input  pipg_pkg::pipg_coord_type    py,
   output pipg_pkg::pipg_lane_out_type lane_out
);

   // stage 2: differences and range flags
   logic signed [pipg_pkg::DIFF_W-1:0] a_in, b_in, c_in, d_in;
   logic signed [pipg_pkg::DIFF_W-1:0] a_ff, b_ff, c_ff, d_ff;
   logic horiz, in_range, count_in, top_hit_in;
   logic count2_ff, top2_ff;

   // stage 3: magnitudes and signs
   logic [pipg_pkg::MAG_W-1:0] ma_in, mb_in, mc_in, md_in;
   logic [pipg_pkg::MAG_W-1:0] ma_ff, mb_ff, mc_ff, md_ff;
   logic pneg_ff, qneg_ff, dneg_ff, pz_ff, qz_ff, count3_ff, top3_ff;

   // stage 4: products
   logic [pipg_pkg::PROD_W-1:0] p_in, q_in, p_ff, q_ff;
   logic pn_ff, qn_ff, dneg4_ff, count4_ff, top4_ff;

   // stage 5: verdict
   logic gt, eq, zero, pos;
   pipg_pkg::pipg_lane_out_type out_in, out_ff;

   always_comb begin
      a_in = pipg_pkg::DIFF_W'(py) - pipg_pkg::DIFF_W'(edge_in.y1);
      b_in = pipg_pkg::DIFF_W'(edge_in.x2) - pipg_pkg::DIFF_W'(edge_in.x1);
      c_in = pipg_pkg::DIFF_W'(px) - pipg_pkg::DIFF_W'(edge_in.x1);
      d_in = pipg_pkg::DIFF_W'(edge_in.y2) - pipg_pkg::DIFF_W'(edge_in.y1);
      horiz = (edge_in.y1 == edge_in.y2);
      if (edge_in.y1 < edge_in.y2) begin
         in_range = (py >= edge_in.y1) && (py < edge_in.y2);
      end else begin
         in_range = (py >= edge_in.y2) && (py < edge_in.y1);
      end
      count_in = edge_in.active && !horiz && in_range;
      // top-level hit: on a horizontal edge at the point's y, or on the edge's top vertex
      if (horiz) begin
         top_hit_in = (edge_in.y1 == py) &&
                      (((edge_in.x1 <= px) && (px <= edge_in.x2)) ||
                       ((edge_in.x2 <= px) && (px <= edge_in.x1)));
      end else if (edge_in.y1 > edge_in.y2) begin
         top_hit_in = (edge_in.y1 == py) && (edge_in.x1 == px);
      end else begin
         top_hit_in = (edge_in.y2 == py) && (edge_in.x2 == px);
      end
      top_hit_in = top_hit_in && edge_in.active;
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         a_ff      <= a_in;
         b_ff      <= b_in;
         c_ff      <= c_in;
         d_ff      <= d_in;
         count2_ff <= count_in;
         top2_ff   <= top_hit_in;
      end
   end

   // differences of two 32-bit values never exceed 2^32-1 in magnitude
   always_comb begin
      ma_in = a_ff[pipg_pkg::DIFF_W-1] ? pipg_pkg::MAG_W'(-a_ff) : pipg_pkg::MAG_W'(a_ff);
      mb_in = b_ff[pipg_pkg::DIFF_W-1] ? pipg_pkg::MAG_W'(-b_ff) : pipg_pkg::MAG_W'(b_ff);
      mc_in = c_ff[pipg_pkg::DIFF_W-1] ? pipg_pkg::MAG_W'(-c_ff) : pipg_pkg::MAG_W'(c_ff);
      md_in = d_ff[pipg_pkg::DIFF_W-1] ? pipg_pkg::MAG_W'(-d_ff) : pipg_pkg::MAG_W'(d_ff);
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         ma_ff     <= ma_in;
         mb_ff     <= mb_in;
         mc_ff     <= mc_in;
         md_ff     <= md_in;
         pneg_ff   <= a_ff[pipg_pkg::DIFF_W-1] ^ b_ff[pipg_pkg::DIFF_W-1];
         qneg_ff   <= c_ff[pipg_pkg::DIFF_W-1] ^ d_ff[pipg_pkg::DIFF_W-1];
         dneg_ff   <= d_ff[pipg_pkg::DIFF_W-1];
         pz_ff     <= (a_ff == '0) || (b_ff == '0);
         qz_ff     <= (c_ff == '0) || (d_ff == '0);
         count3_ff <= count2_ff;
         top3_ff   <= top2_ff;
      end
   end

   always_comb begin
      p_in = pipg_pkg::PROD_W'(ma_ff) * pipg_pkg::PROD_W'(mb_ff);
      q_in = pipg_pkg::PROD_W'(mc_ff) * pipg_pkg::PROD_W'(md_ff);
   end

   always_ff @(posedge clock) begin
      if (en.s4) begin
         p_ff      <= p_in;
         q_ff      <= q_in;
         pn_ff     <= pneg_ff && !pz_ff;
         qn_ff     <= qneg_ff && !qz_ff;
         dneg4_ff  <= dneg_ff;
         count4_ff <= count3_ff;
         top4_ff   <= top3_ff;
      end
   end

   // sign of (py-y1)(x2-x1) - (px-x1)dy, flipped when dy is negative
   always_comb begin
      gt   = (p_ff > q_ff);
      eq   = (p_ff == q_ff);
      zero = 1'b0;
      pos  = 1'b0;
      priority if (pn_ff != qn_ff) begin
         pos = qn_ff;
      end else if (eq) begin
         zero = 1'b1;
      end else if (pn_ff) begin
         pos = !gt;
      end else begin
         pos = gt;
      end
      if (dneg4_ff) begin
         pos = !pos && !zero;
      end
      out_in.crosses = count4_ff && !zero && pos;
      out_in.on_edge = count4_ff && zero;
      out_in.top_hit = top4_ff;
   end

   always_ff @(posedge clock) begin
      if (en.s5) begin
         out_ff <= out_in;
      end
   end

   assign lane_out = out_ff;

endmodule

FILE: design/point_in_polygon_gate.sv
// Point-in-polygon gate, top level: vertex table, top-y scan, pipeline control, CSRs.
// Depends on pipg_pkg, pipg_req_if, pipg_rsp_if and pipg_edge_lane.
// Points: one per cycle unless rsp back-pressure or the top-y scan holds the input off;
// they pass stages 1 to 5, then the result register. A vertex load waits until stage 1
// is empty; it and a vertex_count write start a top-y scan over the n active vertices.
// Reset (synchronous): vertex_count 3, negate 0, top y 0, pipeline empty; table not cleared.
`timescale 1ns / 1ps

module point_in_polygon_gate #(
   parameter int MAX_VERTICES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   pipg_req_if.sink                            req,
   pipg_rsp_if.source                          rsp,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pipg_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [pipg_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [pipg_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);

   // configuration
   logic [pipg_pkg::VCOUNT_W-1:0] vcount_ff;
   logic                          negate_ff;
   logic                          csr_wr, csr_idx;
   logic [CNT_W-1:0]              n_act;

   // vertex table
   pipg_pkg::pipg_coord_type tab_x_ff [MAX_VERTICES];
   pipg_pkg::pipg_coord_type tab_y_ff [MAX_VERTICES];
   logic                     slot_ok;

   // top-y scan
   logic                     scan_busy_ff, scan_busy_in;
   logic [IDX_W-1:0]         scan_idx_ff, scan_idx_in;
   pipg_pkg::pipg_coord_type scan_max_ff, scan_val, scan_max;
   pipg_pkg::pipg_coord_type top_y_ff;
   logic                     scan_last, scan_start;

   // pipeline control
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic adv1, adv2, adv3, adv4, adv5, adv6;
   logic point_acc, load_acc;
   pipg_pkg::pipg_coord_type      px1_ff, py1_ff;
   logic [pipg_pkg::INDEX_W-1:0]  idx1_ff, idx2_ff, idx3_ff, idx4_ff, idx5_ff;
   logic                          top2_ff, top3_ff, top4_ff, top5_ff;
   pipg_pkg::pipg_stage_en_type   lane_en;
   pipg_pkg::pipg_lane_out_type   lane_out [MAX_VERTICES];
   logic [MAX_VERTICES-1:0]       cross_vec, on_vec, top_vec;
   logic                          in_poly, emit;

   // result register
   logic                          rsp_valid_ff;
   logic [pipg_pkg::INDEX_W-1:0]  rsp_idx_ff;

   // ---------------- configuration port ----------------
   assign pready  = 1'b1;
   assign csr_idx = paddr[2];
   assign csr_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= pipg_pkg::VCOUNT_RESET;
         negate_ff <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            pipg_pkg::CSR_IDX_VCOUNT: vcount_ff <= pwdata[pipg_pkg::VCOUNT_W-1:0];
            pipg_pkg::CSR_IDX_NEGATE: negate_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         pipg_pkg::CSR_IDX_VCOUNT:
            prdata = pipg_pkg::CSR_DATA_W'(vcount_ff);
         pipg_pkg::CSR_IDX_NEGATE:
            prdata = pipg_pkg::CSR_DATA_W'(negate_ff);
         default:
            prdata = '0;
      endcase
   end

   always_comb begin
      if (int'(vcount_ff) > MAX_VERTICES) begin
         n_act = CNT_W'(MAX_VERTICES);
      end else if (int'(vcount_ff) < pipg_pkg::MIN_VERTICES) begin
         n_act = CNT_W'(pipg_pkg::MIN_VERTICES);
      end else begin
         n_act = CNT_W'(vcount_ff);
      end
   end

   // ---------------- input handshake ----------------
   assign adv6 = !rsp_valid_ff || rsp.ready;
   assign adv5 = !v5_ff || adv6;
   assign adv4 = !v4_ff || adv5;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;

   // a load must not overwrite the table under a point still waiting in stage 1
   assign req.ready = !scan_busy_ff &&
                      ((req.opcode == pipg_pkg::OP_POINT) ? adv1 : !v1_ff);
   assign point_acc = req.valid && req.ready && (req.opcode == pipg_pkg::OP_POINT);
   assign load_acc  = req.valid && req.ready && (req.opcode == pipg_pkg::OP_LOAD);
   assign slot_ok   = (int'(req.vertex_slot) < MAX_VERTICES);

   always_ff @(posedge clock) begin
      if (load_acc && slot_ok) begin
         tab_x_ff[IDX_W'(req.vertex_slot)] <= req.coord_x;
         tab_y_ff[IDX_W'(req.vertex_slot)] <= req.coord_y;
      end
   end

   // ---------------- top-y scan ----------------
   assign scan_start = (load_acc && slot_ok) ||
                       (csr_wr && (csr_idx == pipg_pkg::CSR_IDX_VCOUNT));

   always_comb begin
      scan_val  = tab_y_ff[scan_idx_ff];
      scan_max  = ((scan_idx_ff == '0) || (scan_val > scan_max_ff)) ? scan_val : scan_max_ff;
      scan_last = ((CNT_W'(scan_idx_ff) + CNT_W'(1)) == n_act);
      scan_busy_in = scan_busy_ff;
      scan_idx_in  = scan_idx_ff;
      if (scan_start) begin
         scan_busy_in = 1'b1;
         scan_idx_in  = '0;
      end else if (scan_busy_ff) begin
         if (scan_last) begin
            scan_busy_in = 1'b0;
         end else begin
            scan_idx_in = scan_idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_busy_ff <= 1'b0;
         scan_idx_ff  <= '0;
         top_y_ff     <= '0;
      end else begin
         scan_busy_ff <= scan_busy_in;
         scan_idx_ff  <= scan_idx_in;
         if (scan_busy_ff && scan_last && !scan_start) begin
            top_y_ff <= scan_max;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (scan_busy_ff) begin
         scan_max_ff <= scan_max;
      end
   end

   // ---------------- point pipeline ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= point_acc;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
         if (adv5) v5_ff <= v4_ff;
         if (adv6) rsp_valid_ff <= v5_ff && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         px1_ff  <= req.coord_x;
         py1_ff  <= req.coord_y;
         idx1_ff <= req.event_index;
      end
      if (adv2) begin
         idx2_ff <= idx1_ff;
         top2_ff <= (py1_ff == top_y_ff);
      end
      if (adv3) begin
         idx3_ff <= idx2_ff;
         top3_ff <= top2_ff;
      end
      if (adv4) begin
         idx4_ff <= idx3_ff;
         top4_ff <= top3_ff;
      end
      if (adv5) begin
         idx5_ff <= idx4_ff;
         top5_ff <= top4_ff;
      end
      if (adv6) begin
         rsp_idx_ff <= idx5_ff;
      end
   end

   assign lane_en.s2 = adv2;
   assign lane_en.s3 = adv3;
   assign lane_en.s4 = adv4;
   assign lane_en.s5 = adv5;

   for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_lane
      localparam int NEXT = (i + 1) % MAX_VERTICES;
      pipg_pkg::pipg_lane_in_type edge_in;
      logic                       close;

      // the last active edge closes back to vertex 0
      assign close          = (CNT_W'(i + 1) == n_act);
      assign edge_in.x1     = tab_x_ff[i];
      assign edge_in.y1     = tab_y_ff[i];
      assign edge_in.x2     = close ? tab_x_ff[0] : tab_x_ff[NEXT];
      assign edge_in.y2     = close ? tab_y_ff[0] : tab_y_ff[NEXT];
      assign edge_in.active = (CNT_W'(i) < n_act);

      pipg_edge_lane u_lane (
         .clock    (clock),
         .en       (lane_en),
         .edge_in  (edge_in),
         .px       (px1_ff),
         .py       (py1_ff),
         .lane_out (lane_out[i])
      );

      assign cross_vec[i] = lane_out[i].crosses;
      assign on_vec[i]    = lane_out[i].on_edge;
      assign top_vec[i]   = lane_out[i].top_hit;
   end

   always_comb begin
      if (top5_ff) begin
         in_poly = |top_vec;
      end else begin
         in_poly = (|on_vec) || (^cross_vec);
      end
      emit = (in_poly != negate_ff);
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.selected_index = rsp_idx_ff;

   // ---------------- checks ----------------
   a_load_stage1_empty: assert property (@(posedge clock) disable iff (reset)
      load_acc |-> !v1_ff)
      else $error("vertex load accepted with a point in stage 1");

   a_no_point_in_scan: assert property (@(posedge clock) disable iff (reset)
      scan_busy_ff |-> !point_acc)
      else $error("point accepted during top-y scan");

   a_load_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (load_acc && slot_ok) |=> (scan_busy_ff && (scan_idx_ff == '0)))
      else $error("vertex load did not restart the top-y scan");

   a_result_only_from_stage5: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && !v5_ff) |=> !rsp_valid_ff)
      else $error("result appeared without a point leaving stage 5");

endmodule
